### src/cdc_pkg.sv
`default_nettype none

package cdc_pkg;

  // Field widths
  localparam int IDX_W    = 32;
  localparam int OFS_W    = 32;
  localparam int LEN_W    = 36;
  localparam int BOUND_W  = 37;
  localparam int STRIDE_W = 14;
  localparam int WIN_W    = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Packed bus widths, padded to whole bytes
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;

  // Raw product widths
  localparam int OFS_PROD_W = IDX_W + STRIDE_W;
  localparam int LEN_PROD_W = IDX_W + 1 + STRIDE_W;

  // Saturation ceiling for region lengths
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Reset values of the configuration registers (64 MB window)
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd16;
  localparam logic                MERGE_RESET  = 1'b1;
  localparam logic [WIN_W-1:0]    WINDOW_RESET = 32'd67108864;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEMENT_STRIDE = 2'd0,
    REG_MERGE_ENABLE   = 2'd1,
    REG_BATCH_WINDOW   = 2'd2
  } cdc_reg_t;

  // One classified descriptor, as the front hands it to the back
  typedef struct packed {
    logic [OFS_W-1:0]   src;
    logic [OFS_W-1:0]   dst;
    logic [LEN_W-1:0]   len;
    logic [BOUND_W-1:0] src_end;
    logic [BOUND_W-1:0] dst_end;
    logic               list_end;
  } cdc_item_t;

  // One emitted region
  typedef struct packed {
    logic [OFS_W-1:0] src_ofs;
    logic [OFS_W-1:0] dst_ofs;
    logic [LEN_W-1:0] region_length;
    logic             new_batch;
    logic             last;
  } cdc_region_t;

endpackage

`default_nettype wire

### src/cdc_front.sv
`default_nettype none

module cdc_front import cdc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [STRIDE_W-1:0] element_stride,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [IDX_W-1:0]    dest_index,
  input  wire logic [IDX_W-1:0]    source_index,
  input  wire logic [IDX_W-1:0]    final_element,
  input  wire logic                list_end,
  input  wire logic [CNT_W-1:0]    q_count,
  output logic                     push,
  output cdc_item_t                push_item
);

  logic                  v1_r;
  logic [OFS_W-1:0]      s1_src_r;
  logic [OFS_W-1:0]      s1_dst_r;
  logic [LEN_PROD_W-1:0] s1_len_r;
  logic                  s1_end_r;
  logic                  v2_r;
  cdc_item_t             s2_item_r;

  logic [OFS_PROD_W-1:0] src_prod;
  logic [OFS_PROD_W-1:0] dst_prod;
  logic [LEN_PROD_W-1:0] len_prod;
  logic [LEN_W-1:0]      len_sat;
  logic [CNT_W:0]        used;
  logic                  accept;

  // Credits: queue entries plus beats still in flight in the two stages.
  assign used     = {1'b0, q_count} + (CNT_W+1)'(v1_r) + (CNT_W+1)'(v2_r);
  assign in_ready = (used < (CNT_W+1)'(DEPTH));
  assign accept   = in_valid && in_ready;

  // Stage one: byte offsets and raw length.
  assign src_prod = {{STRIDE_W{1'b0}}, source_index} * {{IDX_W{1'b0}}, element_stride};
  assign dst_prod = {{STRIDE_W{1'b0}}, dest_index} * {{IDX_W{1'b0}}, element_stride};
  assign len_prod = ({{(STRIDE_W+1){1'b0}}, final_element} + LEN_PROD_W'(1))
                    * {{(IDX_W+1){1'b0}}, element_stride};

  // Stage two: saturate length and form the region end bounds.
  assign len_sat = (|s1_len_r[LEN_PROD_W-1:LEN_W]) ? LEN_MAX : s1_len_r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src_r <= src_prod[OFS_W-1:0];
      s1_dst_r <= dst_prod[OFS_W-1:0];
      s1_len_r <= len_prod;
      s1_end_r <= list_end;
    end
    if (v1_r) begin
      s2_item_r.src      <= s1_src_r;
      s2_item_r.dst      <= s1_dst_r;
      s2_item_r.len      <= len_sat;
      s2_item_r.src_end  <= {{(BOUND_W-OFS_W){1'b0}}, s1_src_r} + {1'b0, len_sat};
      s2_item_r.dst_end  <= {{(BOUND_W-OFS_W){1'b0}}, s1_dst_r} + {1'b0, len_sat};
      s2_item_r.list_end <= s1_end_r;
    end
  end

  assign push      = v2_r;
  assign push_item = s2_item_r;

endmodule

`default_nettype wire

### src/cdc_queue.sv
`default_nettype none

module cdc_queue import cdc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire cdc_item_t  push_item,
  input  wire logic       pop,
  output logic            head_valid,
  output cdc_item_t       head_item,
  output logic [CNT_W-1:0] count
);

  cdc_item_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];
  assign count      = count_r;

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### src/cdc_back.sv
`default_nettype none

module cdc_back import cdc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             merge_enable,
  input  wire logic [WIN_W-1:0] batch_window,
  input  wire logic             head_valid,
  input  wire cdc_item_t        head_item,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cdc_region_t           out_region
);

  // Pending region and open batch
  logic               pend_valid_r, pend_valid_nxt;
  logic [OFS_W-1:0]   pend_src_r, pend_src_nxt;
  logic [OFS_W-1:0]   pend_dst_r, pend_dst_nxt;
  logic [LEN_W-1:0]   pend_len_r, pend_len_nxt;
  logic [BOUND_W-1:0] pend_src_end_r, pend_src_end_nxt;
  logic [BOUND_W-1:0] pend_dst_end_r, pend_dst_end_nxt;
  logic               batch_open_r, batch_open_nxt;
  logic [OFS_W-1:0]   bsrc_low_r, bsrc_low_nxt;
  logic [BOUND_W-1:0] bsrc_high_r, bsrc_high_nxt;
  logic [OFS_W-1:0]   bdst_low_r, bdst_low_nxt;
  logic [BOUND_W-1:0] bdst_high_r, bdst_high_nxt;
  // Set while the current head only waits for its end-of-list flush
  logic               flush_r, flush_nxt;
  // Output register
  logic               out_valid_r, out_valid_nxt;
  cdc_region_t        out_region_r, out_region_nxt;

  logic               slot_free;
  logic               step;
  logic               merge;
  logic [BOUND_W-1:0] len_sum;
  logic               len_ovf;
  logic [LEN_W-1:0]   merged_len;
  logic [BOUND_W-1:0] merged_src_end;
  logic [BOUND_W-1:0] merged_dst_end;
  logic [OFS_W-1:0]   cand_src_low;
  logic [BOUND_W-1:0] cand_src_high;
  logic [OFS_W-1:0]   cand_dst_low;
  logic [BOUND_W-1:0] cand_dst_high;
  logic [BOUND_W-1:0] src_span;
  logic [BOUND_W-1:0] dst_span;
  logic               fits;

  assign slot_free = !out_valid_r || out_ready;
  assign step      = head_valid && slot_free;

  // Contiguity test against the stored end bounds of the pending region.
  assign merge = merge_enable && pend_valid_r
                 && (pend_src_end_r == {{(BOUND_W-OFS_W){1'b0}}, head_item.src})
                 && (pend_dst_end_r == {{(BOUND_W-OFS_W){1'b0}}, head_item.dst});

  // Extended length; on saturation the end bounds move to start plus the ceiling.
  assign len_sum        = {1'b0, pend_len_r} + {1'b0, head_item.len};
  assign len_ovf        = len_sum[LEN_W];
  assign merged_len     = len_ovf ? LEN_MAX : len_sum[LEN_W-1:0];
  assign merged_src_end = len_ovf ? ({{(BOUND_W-OFS_W){1'b0}}, pend_src_r} + {1'b0, LEN_MAX})
                                  : head_item.src_end;
  assign merged_dst_end = len_ovf ? ({{(BOUND_W-OFS_W){1'b0}}, pend_dst_r} + {1'b0, LEN_MAX})
                                  : head_item.dst_end;

  // Batch span test for the pending region.
  assign cand_src_low  = (bsrc_low_r < pend_src_r) ? bsrc_low_r : pend_src_r;
  assign cand_src_high = (bsrc_high_r > pend_src_end_r) ? bsrc_high_r : pend_src_end_r;
  assign cand_dst_low  = (bdst_low_r < pend_dst_r) ? bdst_low_r : pend_dst_r;
  assign cand_dst_high = (bdst_high_r > pend_dst_end_r) ? bdst_high_r : pend_dst_end_r;
  assign src_span = cand_src_high - {{(BOUND_W-OFS_W){1'b0}}, cand_src_low};
  assign dst_span = cand_dst_high - {{(BOUND_W-OFS_W){1'b0}}, cand_dst_low};
  assign fits = batch_open_r
                && (src_span <= {{(BOUND_W-WIN_W){1'b0}}, batch_window})
                && (dst_span <= {{(BOUND_W-WIN_W){1'b0}}, batch_window});

  // Step control: merge, displace, load or flush.
  always_comb begin
    logic emit;
    logic emit_last;
    logic load;

    emit             = 1'b0;
    emit_last        = 1'b0;
    load             = 1'b0;
    pop              = 1'b0;
    pend_valid_nxt   = pend_valid_r;
    pend_src_nxt     = pend_src_r;
    pend_dst_nxt     = pend_dst_r;
    pend_len_nxt     = pend_len_r;
    pend_src_end_nxt = pend_src_end_r;
    pend_dst_end_nxt = pend_dst_end_r;
    batch_open_nxt   = batch_open_r;
    bsrc_low_nxt     = bsrc_low_r;
    bsrc_high_nxt    = bsrc_high_r;
    bdst_low_nxt     = bdst_low_r;
    bdst_high_nxt    = bdst_high_r;
    flush_nxt        = flush_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_region_nxt   = out_region_r;

    if (step) begin
      if (flush_r) begin
        emit      = 1'b1;
        emit_last = 1'b1;
        flush_nxt = 1'b0;
        pop       = 1'b1;
      end else begin
        if (merge) begin
          pend_len_nxt     = merged_len;
          pend_src_end_nxt = merged_src_end;
          pend_dst_end_nxt = merged_dst_end;
        end else begin
          emit = pend_valid_r;
          load = 1'b1;
        end
        if (head_item.list_end) begin
          flush_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end
    end

    // Emit the current pending region and fold it into the batch, or open a new batch.
    if (emit) begin
      batch_open_nxt = 1'b1;
      if (fits) begin
        bsrc_low_nxt  = cand_src_low;
        bsrc_high_nxt = cand_src_high;
        bdst_low_nxt  = cand_dst_low;
        bdst_high_nxt = cand_dst_high;
      end else begin
        bsrc_low_nxt  = pend_src_r;
        bsrc_high_nxt = pend_src_end_r;
        bdst_low_nxt  = pend_dst_r;
        bdst_high_nxt = pend_dst_end_r;
      end
      out_valid_nxt                = 1'b1;
      out_region_nxt.src_ofs       = pend_src_r;
      out_region_nxt.dst_ofs       = pend_dst_r;
      out_region_nxt.region_length = pend_len_r;
      out_region_nxt.new_batch     = !fits;
      out_region_nxt.last          = emit_last;
    end

    // A new pending region takes the place of the displaced one.
    if (load) begin
      pend_valid_nxt   = 1'b1;
      pend_src_nxt     = head_item.src;
      pend_dst_nxt     = head_item.dst;
      pend_len_nxt     = head_item.len;
      pend_src_end_nxt = head_item.src_end;
      pend_dst_end_nxt = head_item.dst_end;
    end

    // The end of the list closes both the pending region and the batch.
    if (emit_last) begin
      pend_valid_nxt = 1'b0;
      batch_open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      batch_open_r <= 1'b0;
      flush_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      batch_open_r <= batch_open_nxt;
      flush_r      <= flush_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_src_r     <= pend_src_nxt;
    pend_dst_r     <= pend_dst_nxt;
    pend_len_r     <= pend_len_nxt;
    pend_src_end_r <= pend_src_end_nxt;
    pend_dst_end_r <= pend_dst_end_nxt;
    bsrc_low_r     <= bsrc_low_nxt;
    bsrc_high_r    <= bsrc_high_nxt;
    bdst_low_r     <= bdst_low_nxt;
    bdst_high_r    <= bdst_high_nxt;
    out_region_r   <= out_region_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_region = out_region_r;

endmodule

`default_nettype wire

### src/copy_descriptor_coalescer.sv
// Channel | Direction | Handshake         | Payload
// in      | input     | in_tvalid/tready  | in_tdata (indexes), in_tlast (list end)
// out     | output    | out_tvalid/tready | out_tdata (region), out_tuser, out_tlast
// cfg     | input     | cfg_we            | cfg_addr, cfg_wdata
//
// One descriptor is accepted per cycle while credits allow; after the multiply stage,
// the saturate stage and the queue, its back-end step loads the output register.
// A descriptor that ends the list holds the back end for a merge or displace step,
// then for the flush step that emits its own region.
// Input ready follows queue credits, so a stalled output backs up through the queue.
// Reset is synchronous; it clears the pending region, the open batch and all valids.
`default_nettype none

module copy_descriptor_coalescer import cdc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [31:0] dest_index, [63:32] source_index, [95:64] final_element
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] source byte offset, [63:32] destination byte offset,
  // [99:64] region_length, [103:100] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] new_batch
  output logic                       out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [STRIDE_W-1:0] stride_r;
  logic                merge_en_r;
  logic [WIN_W-1:0]    window_r;

  logic             push;
  cdc_item_t        push_item;
  logic             pop;
  logic             head_valid;
  cdc_item_t        head_item;
  logic [CNT_W-1:0] q_count;
  cdc_region_t      region;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r   <= STRIDE_RESET;
      merge_en_r <= MERGE_RESET;
      window_r   <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cdc_reg_t'(cfg_addr))
        REG_ELEMENT_STRIDE: stride_r   <= cfg_wdata[STRIDE_W-1:0];
        REG_MERGE_ENABLE:   merge_en_r <= cfg_wdata[0];
        REG_BATCH_WINDOW:   window_r   <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  cdc_front #(.DEPTH(DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .element_stride (stride_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .dest_index     (in_tdata[31:0]),
    .source_index   (in_tdata[63:32]),
    .final_element  (in_tdata[95:64]),
    .list_end       (in_tlast),
    .q_count        (q_count),
    .push           (push),
    .push_item      (push_item)
  );

  cdc_queue #(.DEPTH(DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  cdc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .merge_enable (merge_en_r),
    .batch_window (window_r),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_region   (region)
  );

  // Pack the region onto the output bus.
  assign out_tdata = {4'b0000, region.region_length, region.dst_ofs, region.src_ofs};
  assign out_tuser = region.new_batch;
  assign out_tlast = region.last;

endmodule

`default_nettype wire
